// ===== hw/rtl/ptm_pkg.sv =====
// Shared types, constants and lookup tables for the photoreceptor tone map.
// Depends on nothing; every other file in hw/rtl refers to it by scoped name.
package ptm_pkg;

  // Widths of the item fields and of the working precision
  localparam int PIXEL_WIDTH    = 32;
  localparam int OUT_WIDTH      = 16;
  localparam int LOG_TABLE_BITS = 8;
  localparam int LOG_ENTRIES    = 1 << LOG_TABLE_BITS;

  localparam int WORK_W   = 56;               // saturating Q.16 working width
  localparam int HALF_W   = WORK_W / 2;
  localparam int CIN_W    = PIXEL_WIDTH + 8;  // pixel times Q8.16 gain, floored
  localparam int EXPO_W   = 24;
  localparam int IGAM_W   = 16;
  localparam int CHROMA_W = 17;
  localparam int GAIN_W   = 28;
  localparam int CPOW_W   = 17;
  localparam int GLOB_W   = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int EXP_W   = 20;                // Q.16 exponent into the power unit
  localparam int MANT_W  = 17;                // Q1.16 mantissa from the exp2 table
  localparam int LG_W    = 23;                // signed Q7.16 log2
  localparam int T_W     = LG_W + EXP_W + 1 - 16;
  localparam int K_MAX   = 40;                // largest left shift before saturation
  localparam int DEN_W   = 47;
  localparam int RATIO_W = 17;
  localparam int REM_W   = DEN_W + 16;
  localparam int OCONV_W = 40;

  localparam logic [WORK_W-1:0]   WORK_MAX = '1;
  localparam logic [MANT_W-1:0]   ONE_Q16  = 17'h10000;
  localparam logic [15:0]         LUMA_R   = 16'd13937;
  localparam logic [15:0]         LUMA_G   = 16'd46870;
  localparam logic [15:0]         LUMA_B   = 16'd4730;

  // Pipeline depths
  localparam int POW_LAT   = 5;
  localparam int DIV_LAT   = RATIO_W;
  localparam int CIN_DLY   = 4 + POW_LAT;
  localparam int LANE_LAT  = 4 + POW_LAT + 2 + DIV_LAT + POW_LAT + 1;
  localparam int FRONT_LAT = 2;
  localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPOSURE     = 4'd0,
    REG_INV_GAMMA    = 4'd1,
    REG_CHROMA       = 4'd2,
    REG_LIGHT_GAIN   = 4'd3,
    REG_CONTRAST     = 4'd4,
    REG_GLOBAL_RED   = 4'd5,
    REG_GLOBAL_GREEN = 4'd6,
    REG_GLOBAL_BLUE  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PIXEL_WIDTH-1:0] in_red;
    logic [PIXEL_WIDTH-1:0] in_green;
    logic [PIXEL_WIDTH-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] out_red;
    logic [OUT_WIDTH-1:0] out_green;
    logic [OUT_WIDTH-1:0] out_blue;
  } pix_out_t;

  // Settings shared by all lanes
  typedef struct packed {
    logic [CHROMA_W-1:0] chroma;
    logic [GAIN_W-1:0]   light;
    logic [CPOW_W-1:0]   cpow;
    logic [IGAM_W-1:0]   igam;
  } lane_cfg_t;

  typedef logic [15:0]       log_tab_t [LOG_ENTRIES];
  typedef logic [MANT_W-1:0] exp_tab_t [LOG_ENTRIES];

  // log2 of a Q2.30 mantissa in [1,2) by truncating repeated squaring, Q0.16
  function automatic logic [15:0] mant_log2(input logic [63:0] xin);
    logic [63:0] x;
    logic [15:0] r;
    x = xin;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      r = {r[14:0], 1'b0};
      if (x >= 64'h8000_0000) begin
        r[0] = 1'b1;
        x    = x >> 1;
      end
    end
    return r;
  endfunction

  function automatic log_tab_t make_log_tab();
    log_tab_t t;
    for (int i = 0; i < LOG_ENTRIES; i++) begin
      t[i] = mant_log2((64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS)));
    end
    return t;
  endfunction

  // Smallest Q1.16 value whose log2 reaches j/2^B, by binary search
  function automatic exp_tab_t make_exp_tab();
    exp_tab_t    t;
    logic [17:0] lo;
    logic [17:0] hi;
    logic [17:0] mid;
    logic [15:0] target;
    for (int j = 0; j < LOG_ENTRIES; j++) begin
      target = 16'(j << (16 - LOG_TABLE_BITS));
      lo = 18'h10000;
      hi = 18'h20000;
      for (int it = 0; it < 18; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (mant_log2(64'(mid) << 14) >= target) begin
            hi = mid;
          end else begin
            lo = mid + 18'd1;
          end
        end
      end
      t[j] = lo[MANT_W-1:0];
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = make_log_tab();
  localparam exp_tab_t EXP_TAB = make_exp_tab();

  // Product shifted right by 16, saturated when the product reaches 2^64
  function automatic logic [WORK_W-1:0] mul_sat(input logic [127:0] prod);
    return (|prod[127:64]) ? WORK_MAX : prod[WORK_W+15:16];
  endfunction

endpackage

// ===== hw/rtl/photoreceptor_tone_map.sv =====
// Photoreceptor tone map: one HDR RGB pixel in, one display RGB pixel out, every
// clock unless in_stall is high. The datapath is fully pipelined, the largest
// share of its depth in the 17-stage restoring divider of each lane. Three
// colour lanes run side by side after a shared exposure and luminance front end,
// and a two-entry output buffer lets one more item in while a finished pixel
// waits. The lanes read the registers at several stages, so write them only
// while no item is in flight.
// Depends on ptm_pkg, ptm_lane, ptm_pow and ptm_div.
module photoreceptor_tone_map (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ptm_pkg::pix_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ptm_pkg::pix_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [ptm_pkg::EXPO_W-1:0]   expo_r;
  logic [ptm_pkg::IGAM_W-1:0]   igam_r;
  logic [ptm_pkg::CHROMA_W-1:0] chroma_r;
  logic [ptm_pkg::GAIN_W-1:0]   light_r;
  logic [ptm_pkg::CPOW_W-1:0]   cpow_r;
  logic [ptm_pkg::GLOB_W-1:0]   glob_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expo_r    <= 24'd65536;
      igam_r    <= 16'd1862;
      chroma_r  <= '0;
      light_r   <= 28'd65536;
      cpow_r    <= 17'd65536;
      glob_r[0] <= '0;
      glob_r[1] <= '0;
      glob_r[2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ptm_pkg::cfg_reg_t'(cfg_index))
        ptm_pkg::REG_EXPOSURE:     expo_r    <= cfg_data[ptm_pkg::EXPO_W-1:0];
        ptm_pkg::REG_INV_GAMMA:    igam_r    <= cfg_data[ptm_pkg::IGAM_W-1:0];
        ptm_pkg::REG_CHROMA:       chroma_r  <= cfg_data[ptm_pkg::CHROMA_W-1:0];
        ptm_pkg::REG_LIGHT_GAIN:   light_r   <= cfg_data[ptm_pkg::GAIN_W-1:0];
        ptm_pkg::REG_CONTRAST:     cpow_r    <= cfg_data[ptm_pkg::CPOW_W-1:0];
        ptm_pkg::REG_GLOBAL_RED:   glob_r[0] <= cfg_data[ptm_pkg::GLOB_W-1:0];
        ptm_pkg::REG_GLOBAL_GREEN: glob_r[1] <= cfg_data[ptm_pkg::GLOB_W-1:0];
        ptm_pkg::REG_GLOBAL_BLUE:  glob_r[2] <= cfg_data[ptm_pkg::GLOB_W-1:0];
        default: ;
      endcase
    end
  end

  ptm_pkg::lane_cfg_t lane_cfg;

  assign lane_cfg = '{chroma: chroma_r, light: light_r, cpow: cpow_r, igam: igam_r};

  // Flow control: the whole pipe advances while the output buffer has room
  logic [1:0] cnt_r, cnt_nxt;
  logic       en, push, pop;
  logic       vld_r [ptm_pkg::PIPE_LAT];

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;
  assign pop      = out_valid && !out_stall;
  assign push     = en && vld_r[ptm_pkg::PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptm_pkg::PIPE_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < ptm_pkg::PIPE_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // S1: apply exposure to each channel
  localparam int XP_W = ptm_pkg::PIXEL_WIDTH + ptm_pkg::EXPO_W;
  logic [XP_W-1:0]           xp [3];
  logic [ptm_pkg::CIN_W-1:0] cin_r [3];

  assign xp[0] = in_data.in_red   * expo_r;
  assign xp[1] = in_data.in_green * expo_r;
  assign xp[2] = in_data.in_blue  * expo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        cin_r[c] <= xp[c][ptm_pkg::CIN_W+15:16];
      end
    end
  end

  // S2: merge the channels into Rec.709 luminance
  localparam int LP_W = ptm_pkg::CIN_W + 16;
  logic [LP_W-1:0]             lr, lg, lb;
  logic [ptm_pkg::CIN_W+1:0]   lsum;
  logic [ptm_pkg::WORK_W-1:0]  lum_r;
  logic [ptm_pkg::CIN_W-1:0]   cin2_r [3];

  always_comb begin
    lr   = cin_r[0] * ptm_pkg::LUMA_R;
    lg   = cin_r[1] * ptm_pkg::LUMA_G;
    lb   = cin_r[2] * ptm_pkg::LUMA_B;
    lsum = (ptm_pkg::CIN_W+2)'(lr[LP_W-1:16]) + (ptm_pkg::CIN_W+2)'(lg[LP_W-1:16]) +
           (ptm_pkg::CIN_W+2)'(lb[LP_W-1:16]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lum_r <= (lsum > ptm_pkg::WORK_MAX) ? ptm_pkg::WORK_MAX : ptm_pkg::WORK_W'(lsum);
      for (int c = 0; c < 3; c++) begin
        cin2_r[c] <= cin_r[c];
      end
    end
  end

  // Colour lanes
  logic [ptm_pkg::OUT_WIDTH-1:0] ch_out [3];

  ptm_lane u_lane_red (
    .clk (clk), .en (en), .cfg (lane_cfg), .glob (glob_r[0]),
    .cin (cin2_r[0]), .lum (lum_r), .ch_out (ch_out[0])
  );

  ptm_lane u_lane_green (
    .clk (clk), .en (en), .cfg (lane_cfg), .glob (glob_r[1]),
    .cin (cin2_r[1]), .lum (lum_r), .ch_out (ch_out[1])
  );

  ptm_lane u_lane_blue (
    .clk (clk), .en (en), .cfg (lane_cfg), .glob (glob_r[2]),
    .cin (cin2_r[2]), .lum (lum_r), .ch_out (ch_out[2])
  );

  // Output buffer: head register plus one skid entry
  ptm_pkg::pix_out_t res, head_r, head_nxt, skid_r, skid_nxt;

  assign res = '{out_red: ch_out[0], out_green: ch_out[1], out_blue: ch_out[2]};

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    unique case ({push, pop})
      2'b10: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd0) begin
          head_nxt = res;
        end else begin
          skid_nxt = res;
        end
      end
      2'b01: begin
        cnt_nxt  = cnt_r - 2'd1;
        head_nxt = skid_r;
      end
      2'b11: begin
        head_nxt = res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("pushed item not counted");

  a_drop_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_valid && !out_stall))
    else $error("result vanished without being taken");

  a_stall_means_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with nothing waiting at the output");
`endif

endmodule

// ===== hw/rtl/ptm_pow.sv =====
// Pipelined fixed-point power unit: x^e = exp2(floor(log2(x) * e)), five stages.
// Depends on ptm_pkg for widths and the log2/exp2 tables.
module ptm_pow (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ptm_pkg::WORK_W-1:0]  x,
  input  logic [ptm_pkg::EXP_W-1:0]   e,
  input  logic                        kill,
  output logic [ptm_pkg::WORK_W-1:0]  y
);

  localparam int NBYTE = ptm_pkg::WORK_W / 8;
  localparam int B     = ptm_pkg::LOG_TABLE_BITS;

  // Stage A: coarse leading-one search by byte
  logic [ptm_pkg::WORK_W-1:0] xa_r;
  logic [ptm_pkg::EXP_W-1:0]  ea_r;
  logic                       killa_r;
  logic [2:0]                 bsel_r, bsel_nxt;

  always_comb begin
    bsel_nxt = '0;
    for (int i = 0; i < NBYTE; i++) begin
      if (|x[i*8 +: 8]) begin
        bsel_nxt = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r    <= x;
      ea_r    <= e;
      killa_r <= kill;
      bsel_r  <= bsel_nxt;
    end
  end

  // Stage B: fine search within the byte, flag the special cases
  logic [ptm_pkg::WORK_W-1:0] xb_r;
  logic [ptm_pkg::EXP_W-1:0]  eb_r;
  logic [5:0]                 pb_r;
  logic                       killb_r, xzb_r, ezb_r;
  logic [7:0]                 byte_sel;
  logic [2:0]                 fine;

  always_comb begin
    byte_sel = xa_r[bsel_r*8 +: 8];
    fine = '0;
    for (int i = 0; i < 8; i++) begin
      if (byte_sel[i]) begin
        fine = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xb_r    <= xa_r;
      eb_r    <= ea_r;
      pb_r    <= {bsel_r, fine};
      killb_r <= killa_r;
      xzb_r   <= (xa_r == '0);
      ezb_r   <= (ea_r == '0);
    end
  end

  // Stage C: table log2
  logic signed [ptm_pkg::LG_W-1:0] lgc_r, lg_nxt;
  logic [ptm_pkg::EXP_W-1:0]       ec_r;
  logic                            killc_r, xzc_r, ezc_r;
  logic [ptm_pkg::WORK_W+B-1:0]    xshift;
  logic signed [6:0]               pm16;

  always_comb begin
    xshift = {xb_r, B'(0)} >> pb_r;
    pm16   = $signed({1'b0, pb_r}) - 7'sd16;
    lg_nxt = {pm16, ptm_pkg::LOG_TAB[xshift[B-1:0]]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lgc_r   <= lg_nxt;
      ec_r    <= eb_r;
      killc_r <= killb_r;
      xzc_r   <= xzb_r;
      ezc_r   <= ezb_r;
    end
  end

  // Stage D: scale the log by the exponent, floor
  logic signed [ptm_pkg::LG_W+ptm_pkg::EXP_W:0] lprod;
  logic [ptm_pkg::T_W-1:0]                      td_r;
  logic                                         killd_r, xzd_r, ezd_r;

  assign lprod = lgc_r * $signed({1'b0, ec_r});

  always_ff @(posedge clk) begin
    if (en) begin
      td_r    <= lprod[ptm_pkg::T_W+15:16];
      killd_r <= killc_r;
      xzd_r   <= xzc_r;
      ezd_r   <= ezc_r;
    end
  end

  // Stage E: table exp2 and shift by the integer part
  logic signed [11:0]           k;
  logic [11:0]                  nk;
  logic [ptm_pkg::MANT_W-1:0]   mant;
  logic [ptm_pkg::WORK_W:0]     up;
  logic [ptm_pkg::WORK_W-1:0]   y_nxt;
  logic [ptm_pkg::WORK_W-1:0]   y_r;

  always_comb begin
    k    = td_r[ptm_pkg::T_W-1:16];
    nk   = 12'(-k);
    mant = ptm_pkg::EXP_TAB[td_r[15 -: B]];
    up   = (ptm_pkg::WORK_W+1)'(mant) << k[5:0];
    priority if (killd_r) begin
      y_nxt = '0;
    end else if (ezd_r) begin
      y_nxt = ptm_pkg::WORK_W'(ptm_pkg::ONE_Q16);
    end else if (xzd_r) begin
      y_nxt = '0;
    end else if (!k[11]) begin
      if (k > 12'(ptm_pkg::K_MAX)) begin
        y_nxt = ptm_pkg::WORK_MAX;
      end else if (up[ptm_pkg::WORK_W]) begin
        y_nxt = ptm_pkg::WORK_MAX;
      end else begin
        y_nxt = up[ptm_pkg::WORK_W-1:0];
      end
    end else if (nk >= 12'(ptm_pkg::MANT_W)) begin
      y_nxt = '0;
    end else begin
      y_nxt = ptm_pkg::WORK_W'(mant >> nk[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

// ===== hw/rtl/ptm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, quotient below 2^17.
// Depends on ptm_pkg for widths; carries a zero-divisor flag alongside.
module ptm_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ptm_pkg::DEN_W-1:0]    num,
  input  logic [ptm_pkg::DEN_W-1:0]    den,
  input  logic                         dz_in,
  output logic [ptm_pkg::RATIO_W-1:0]  q,
  output logic                         dz
);

  localparam int NS = ptm_pkg::RATIO_W;

  logic [ptm_pkg::REM_W-1:0]   rem_r [NS];
  logic [ptm_pkg::REM_W-1:0]   rem_nxt [NS];
  logic [ptm_pkg::DEN_W-1:0]   den_r [NS];
  logic [ptm_pkg::DEN_W-1:0]   den_nxt [NS];
  logic [ptm_pkg::RATIO_W-1:0] q_r [NS];
  logic [ptm_pkg::RATIO_W-1:0] q_nxt [NS];
  logic                        dz_r [NS];
  logic                        dz_nxt [NS];
  logic [ptm_pkg::REM_W-1:0]   rin [NS];
  logic [ptm_pkg::REM_W-1:0]   dsh [NS];
  logic [ptm_pkg::RATIO_W-1:0] qin [NS];
  logic                        ge [NS];

  // Each stage tries the divisor at its own bit weight
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rin[s]     = {num, 16'b0};
        den_nxt[s] = den;
        qin[s]     = '0;
        dz_nxt[s]  = dz_in;
      end else begin
        rin[s]     = rem_r[s-1];
        den_nxt[s] = den_r[s-1];
        qin[s]     = q_r[s-1];
        dz_nxt[s]  = dz_r[s-1];
      end
      dsh[s] = ptm_pkg::REM_W'(den_nxt[s]) << (NS - 1 - s);
      ge[s]  = (rin[s] >= dsh[s]);
      rem_nxt[s] = ge[s] ? (rin[s] - dsh[s]) : rin[s];
      q_nxt[s]   = qin[s];
      q_nxt[s][NS-1-s] = ge[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_nxt[s];
        q_r[s]   <= q_nxt[s];
        dz_r[s]  <= dz_nxt[s];
      end
    end
  end

  assign q  = q_r[NS-1];
  assign dz = dz_r[NS-1];

endmodule

// ===== hw/rtl/ptm_lane.sv =====
// One colour lane: adaptation, semisaturation power, ratio, gamma and output scaling.
// Depends on ptm_pkg, ptm_pow and ptm_div.
module ptm_lane (
  input  logic                          clk,
  input  logic                          en,
  input  ptm_pkg::lane_cfg_t            cfg,
  input  logic [ptm_pkg::GLOB_W-1:0]    glob,
  input  logic [ptm_pkg::CIN_W-1:0]     cin,
  input  logic [ptm_pkg::WORK_W-1:0]    lum,
  output logic [ptm_pkg::OUT_WIDTH-1:0] ch_out
);

  // L1: mix the channel and the luminance by the chromatic factor
  logic [ptm_pkg::CHROMA_W-1:0]                  cmix, omc;
  logic [ptm_pkg::CIN_W+ptm_pkg::CHROMA_W-1:0]   aprod;
  logic [ptm_pkg::WORK_W+ptm_pkg::CHROMA_W-1:0]  bprod;
  logic [ptm_pkg::CIN_W-1:0]                     a_r;
  logic [ptm_pkg::WORK_W-1:0]                    b_r;

  always_comb begin
    cmix  = (cfg.chroma > ptm_pkg::ONE_Q16) ? ptm_pkg::ONE_Q16 : cfg.chroma;
    omc   = ptm_pkg::ONE_Q16 - cmix;
    aprod = cin * cmix;
    bprod = lum * omc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= aprod[ptm_pkg::CIN_W+15:16];
      b_r <= ptm_pkg::mul_sat(128'(bprod));
    end
  end

  // L2: local adaptation sum, saturated
  logic [ptm_pkg::WORK_W:0]   il_sum;
  logic [ptm_pkg::WORK_W-1:0] il_r;

  assign il_sum = (ptm_pkg::WORK_W+1)'(a_r) + (ptm_pkg::WORK_W+1)'(b_r);

  always_ff @(posedge clk) begin
    if (en) begin
      il_r <= il_sum[ptm_pkg::WORK_W] ? ptm_pkg::WORK_MAX : il_sum[ptm_pkg::WORK_W-1:0];
    end
  end

  // L3: light gain times adaptation, split into two half products
  logic [ptm_pkg::GAIN_W+ptm_pkg::HALF_W-1:0] plo_r, phi_r;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= cfg.light * il_r[ptm_pkg::HALF_W-1:0];
      phi_r <= cfg.light * il_r[ptm_pkg::WORK_W-1:ptm_pkg::HALF_W];
    end
  end

  // L4: join the halves, add the global term
  localparam int PW = ptm_pkg::GAIN_W + ptm_pkg::WORK_W;
  logic [PW-1:0]              lprod;
  logic [ptm_pkg::WORK_W-1:0] lsat;
  logic [ptm_pkg::WORK_W:0]   gsum;
  logic [ptm_pkg::WORK_W-1:0] sum_r;

  always_comb begin
    lprod = PW'(plo_r) + (PW'(phi_r) << ptm_pkg::HALF_W);
    lsat  = ptm_pkg::mul_sat(128'(lprod));
    gsum  = (ptm_pkg::WORK_W+1)'(lsat) + (ptm_pkg::WORK_W+1)'(glob);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= gsum[ptm_pkg::WORK_W] ? ptm_pkg::WORK_MAX : gsum[ptm_pkg::WORK_W-1:0];
    end
  end

  // Semisaturation: sum raised to the contrast power
  logic [ptm_pkg::WORK_W-1:0] sigma;

  ptm_pow u_pow_sigma (
    .clk  (clk),
    .en   (en),
    .x    (sum_r),
    .e    (ptm_pkg::EXP_W'(cfg.cpow)),
    .kill (1'b0),
    .y    (sigma)
  );

  // Hold the channel value until sigma is ready
  logic [ptm_pkg::CIN_W-1:0] cin_dly_r [ptm_pkg::CIN_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      cin_dly_r[0] <= cin;
      for (int i = 1; i < ptm_pkg::CIN_DLY; i++) begin
        cin_dly_r[i] <= cin_dly_r[i-1];
      end
    end
  end

  // N1: denominator
  logic [ptm_pkg::WORK_W:0]  den_r;
  logic [ptm_pkg::CIN_W-1:0] num_r;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= (ptm_pkg::WORK_W+1)'(sigma) +
               (ptm_pkg::WORK_W+1)'(cin_dly_r[ptm_pkg::CIN_DLY-1]);
      num_r <= cin_dly_r[ptm_pkg::CIN_DLY-1];
    end
  end

  // N2: shift numerator and denominator together until the denominator fits
  logic [3:0]                sh;
  logic [ptm_pkg::DEN_W-1:0] nsh_r, dsh_r;
  logic                      dz_r;

  always_comb begin
    sh = '0;
    for (int i = ptm_pkg::DEN_W; i <= ptm_pkg::WORK_W; i++) begin
      if (den_r[i]) begin
        sh = 4'(i - ptm_pkg::DEN_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nsh_r <= ptm_pkg::DEN_W'(num_r >> sh);
      dsh_r <= ptm_pkg::DEN_W'(den_r >> sh);
      dz_r  <= (den_r == '0);
    end
  end

  // Ratio C / (C + sigma)
  logic [ptm_pkg::RATIO_W-1:0] ratio;
  logic                        ratio_dz;

  ptm_div u_div (
    .clk   (clk),
    .en    (en),
    .num   (nsh_r),
    .den   (dsh_r),
    .dz_in (dz_r),
    .q     (ratio),
    .dz    (ratio_dz)
  );

  // Display gamma; a zero denominator forces a zero result
  logic [ptm_pkg::WORK_W-1:0] gval;

  ptm_pow u_pow_gamma (
    .clk  (clk),
    .en   (en),
    .x    (ptm_pkg::WORK_W'(ratio)),
    .e    ({cfg.igam, 4'b0}),
    .kill (ratio_dz),
    .y    (gval)
  );

  // O1: clamp to one and scale to the output width
  logic [ptm_pkg::OCONV_W-1:0]   oconv;
  logic [ptm_pkg::OUT_WIDTH-1:0] out_r;

  assign oconv = {gval[15:0], 24'b0} >> (ptm_pkg::OCONV_W - ptm_pkg::OUT_WIDTH);

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= (|gval[ptm_pkg::WORK_W-1:16]) ? '1 : oconv[ptm_pkg::OUT_WIDTH-1:0];
    end
  end

  assign ch_out = out_r;

endmodule

// ===== tb/sv/photoreceptor_tone_map_tb.sv =====
// Testbench for photoreceptor_tone_map: random and directed pixels checked
// against an in-bench fixed-point predictor held in a small scoreboard class.
// Depends on ptm_pkg for the item types and register indexes.
module photoreceptor_tone_map_tb;

  localparam logic [3:0]  REG_UNUSED  = 4'd9;
  localparam logic [63:0] SAT_LIMIT   = (64'd1 << 56) - 1;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          NUM_PHASES  = 15;

  // Holds the register copy, the lookup tables and the pixels still due
  class tone_scoreboard;
    logic [63:0]       expo, igam, chroma, light, cpow;
    logic [63:0]       glob [3];
    logic [15:0]       log_lut [256];
    logic [16:0]       exp_lut [256];
    ptm_pkg::pix_out_t due_q [$];
    int                errors;
    int                checked;

    function new();
      logic [63:0] lo, hi, mid;
      for (int i = 0; i < 256; i++) begin
        log_lut[i] = 16'(sq_log2((64'd1 << 30) + (64'(i) << 22)));
        lo = 64'h10000;
        hi = 64'h20000;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (sq_log2(mid << 14) >= 64'(i << 8)) hi = mid;
          else lo = mid + 1;
        end
        exp_lut[i] = 17'(lo);
      end
      expo = 65536; igam = 1862; chroma = 0; light = 65536; cpow = 65536;
      glob[0] = 0; glob[1] = 0; glob[2] = 0;
      errors = 0;
      checked = 0;
    endfunction

    // log2 of a Q2.30 mantissa by truncating repeated squaring
    function logic [63:0] sq_log2(logic [63:0] m);
      logic [63:0] x, r;
      x = m;
      r = 0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= 64'h8000_0000) begin
          r = r | 1;
          x = x >> 1;
        end
      end
      return r;
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] d);
      case (idx)
        ptm_pkg::REG_EXPOSURE:     expo    = 64'(d[23:0]);
        ptm_pkg::REG_INV_GAMMA:    igam    = 64'(d[15:0]);
        ptm_pkg::REG_CHROMA:       chroma  = 64'(d[16:0]);
        ptm_pkg::REG_LIGHT_GAIN:   light   = 64'(d[27:0]);
        ptm_pkg::REG_CONTRAST:     cpow    = 64'(d[16:0]);
        ptm_pkg::REG_GLOBAL_RED:   glob[0] = 64'(d);
        ptm_pkg::REG_GLOBAL_GREEN: glob[1] = 64'(d);
        ptm_pkg::REG_GLOBAL_BLUE:  glob[2] = 64'(d);
        default: ;
      endcase
    endfunction

    function logic [63:0] mul_q16(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:64] != 0) return SAT_LIMIT;
      p = p >> 16;
      return (p[63:0] > SAT_LIMIT) ? SAT_LIMIT : p[63:0];
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : s[63:0];
    endfunction

    // x^e through the log2 and exp2 tables
    function logic [63:0] power_q16(logic [63:0] x, logic [63:0] e);
      int          msb;
      logic [63:0] idx, v, tb;
      longint      lg, t, k;
      logic [16:0] mant;
      if (e == 0) return 64'd65536;
      if (x == 0) return 64'd0;
      msb = 63;
      while (!x[msb]) msb--;
      if (msb >= 8) idx = (x >> (msb - 8)) & 64'hFF;
      else idx = (x << (8 - msb)) & 64'hFF;
      lg = longint'(msb - 16) * 65536 + longint'(log_lut[idx[7:0]]);
      t = (lg * longint'(e)) >>> 16;
      k = t >>> 16;
      tb = t;
      mant = exp_lut[tb[15:8]];
      if (k >= 0) begin
        if (k > 40) return SAT_LIMIT;
        v = 64'(mant) << k;
        return (v > SAT_LIMIT) ? SAT_LIMIT : v;
      end
      if (-k >= 63) return 64'd0;
      return 64'(mant) >> (-k);
    endfunction

    function logic [15:0] map_lane(logic [63:0] cin, logic [63:0] lum, logic [63:0] g);
      logic [63:0] c, il, sum, sigma, num, den, ratio, v;
      c = (chroma > 65536) ? 64'd65536 : chroma;
      il = add_sat(mul_q16(cin, c), mul_q16(lum, 64'd65536 - c));
      sum = add_sat(mul_q16(light, il), g);
      sigma = power_q16(sum, cpow);
      num = cin;
      den = cin + sigma;
      if (den == 0) return 16'd0;
      while (den >= (64'd1 << 47)) begin
        den = den >> 1;
        num = num >> 1;
      end
      ratio = (num << 16) / den;
      v = power_q16(ratio, igam << 4);
      if (v >= 65536) return 16'hFFFF;
      return v[15:0];
    endfunction

    // Work out the pixel an accepted item must produce and queue it
    function void note_pixel(ptm_pkg::pix_in_t p);
      logic [63:0]       r, g, b, lum;
      ptm_pkg::pix_out_t o;
      r = mul_q16(64'(p.in_red), expo);
      g = mul_q16(64'(p.in_green), expo);
      b = mul_q16(64'(p.in_blue), expo);
      lum = add_sat(add_sat(mul_q16(r, 64'(ptm_pkg::LUMA_R)),
                            mul_q16(g, 64'(ptm_pkg::LUMA_G))),
                    mul_q16(b, 64'(ptm_pkg::LUMA_B)));
      o.out_red   = map_lane(r, lum, glob[0]);
      o.out_green = map_lane(g, lum, glob[1]);
      o.out_blue  = map_lane(b, lum, glob[2]);
      due_q.push_back(o);
    endfunction

    function void check_pixel(ptm_pkg::pix_out_t o);
      ptm_pkg::pix_out_t e;
      checked++;
      if (due_q.size() == 0) begin
        $error("result with nothing expected: %h", o);
        errors++;
        return;
      end
      e = due_q.pop_front();
      if (o.out_red !== e.out_red) begin
        $error("out_red expected %0d actual %0d", e.out_red, o.out_red);
        errors++;
      end
      if (o.out_green !== e.out_green) begin
        $error("out_green expected %0d actual %0d", e.out_green, o.out_green);
        errors++;
      end
      if (o.out_blue !== e.out_blue) begin
        $error("out_blue expected %0d actual %0d", e.out_blue, o.out_blue);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  ptm_pkg::pix_in_t               in_data;
  logic                           out_valid;
  logic                           out_stall;
  ptm_pkg::pix_out_t              out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ptm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ptm_pkg::CFG_DATA_W-1:0] cfg_data;

  tone_scoreboard sb = new();
  int             cycles;
  int             sent;
  int             gap_pct;
  int             stall_pct;
  logic [31:0]    reg_vals [8];

  photoreceptor_tone_map dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_data);
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rand_chan();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(65535);
      2: return $urandom >> $urandom_range(31);
      3: return 32'd0;
      4: return 32'hFFFF_FFFF;
      default: return $urandom_range(1 << 20);
    endcase
  endfunction

  function automatic ptm_pkg::pix_in_t rand_pixel();
    ptm_pkg::pix_in_t p;
    p.in_red   = rand_chan();
    p.in_green = rand_chan();
    p.in_blue  = rand_chan();
    return p;
  endfunction

  // Write all registers from reg_vals, plus one write to an unused index
  task automatic program_regs();
    for (int i = 0; i < 9; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 8) ? REG_UNUSED : 4'(i);
      cfg_data  <= (i == 8) ? $urandom : reg_vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(cfg_index, cfg_data);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item and hold it until accepted
  task automatic send_pixel(ptm_pkg::pix_in_t p);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(p);
    sent++;
  endtask

  // Drop valid and wait until every expected pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (ptm_pkg::PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic void random_regs();
    reg_vals[ptm_pkg::REG_EXPOSURE] =
      ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1 << 18));
    reg_vals[ptm_pkg::REG_INV_GAMMA] =
      ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(800, 6000));
    reg_vals[ptm_pkg::REG_CHROMA] =
      ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(65536));
    reg_vals[ptm_pkg::REG_LIGHT_GAIN] = $urandom >> $urandom_range(4, 20);
    reg_vals[ptm_pkg::REG_CONTRAST] =
      ($urandom_range(5) == 0) ? $urandom : 32'($urandom_range(19661, 65536));
    reg_vals[ptm_pkg::REG_GLOBAL_RED]   = $urandom >> $urandom_range(31);
    reg_vals[ptm_pkg::REG_GLOBAL_GREEN] = $urandom >> $urandom_range(31);
    reg_vals[ptm_pkg::REG_GLOBAL_BLUE]  = $urandom >> $urandom_range(31);
  endfunction

  initial begin
    ptm_pkg::pix_in_t p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    sent = 0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Pick the idling regime for this third of the run
      gap_pct   = (ph < 5) ? 27 : (ph < 10) ? 78 : 0;
      stall_pct = (ph < 5) ? 78 : (ph < 10) ? 27 : 0;
      case (ph)
        0: ; // registers at reset values
        1: begin
          // all registers at their top, chroma above one
          foreach (reg_vals[i]) reg_vals[i] = 32'hFFFF_FFFF;
          program_regs();
        end
        2: begin
          // zero exponents and zero globals: pow gives one
          foreach (reg_vals[i]) reg_vals[i] = 32'd0;
          program_regs();
        end
        3: begin
          // lowest contrast, unit chroma
          random_regs();
          reg_vals[ptm_pkg::REG_CONTRAST] = 32'd19661;
          reg_vals[ptm_pkg::REG_CHROMA]   = 32'd65536;
          program_regs();
        end
        default: begin
          random_regs();
          program_regs();
        end
      endcase

      // Directed corners: zero pixel, full-scale pixel, single hot channels
      if (ph < 3) begin
        send_pixel('0);
        send_pixel('1);
        p = '0; p.in_red = '1;   send_pixel(p);
        p = '0; p.in_green = '1; send_pixel(p);
        p = '0; p.in_blue = '1;  send_pixel(p);
        p = '0; p.in_red = 32'h0001_0000; p.in_green = 32'd1; p.in_blue = 32'h8000_0000;
        send_pixel(p);
        p = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001};
        send_pixel(p);
      end

      for (int n = 0; n < 85; n++) begin
        send_pixel(rand_pixel());
        // Let the pipeline run dry once mid-stream
        if (ph == 4 && n == 40) drain();
      end
      drain();
    end

    $display("Sent %0d pixels over %0d register settings, %0d results checked.",
             sent, NUM_PHASES, sb.checked);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
